/* hw/rtl/fpsa_pkg.sv */
// Shared types and constants for the free-page stack allocator.
// Used by fpsa_ctrl, fpsa_dp and free_page_stack_allocator_top.
package fpsa_pkg;

  localparam logic [2:0] ACT_ALLOC_ONE = 3'd0;
  localparam logic [2:0] ACT_FREE_ONE  = 3'd1;
  localparam logic [2:0] ACT_ALLOC_RUN = 3'd2;
  localparam logic [2:0] ACT_FREE_RUN  = 3'd3;
  localparam logic [2:0] ACT_RESERVE   = 3'd4;

  localparam logic CFG_MIN_ADDRESS = 1'b0;
  localparam logic CFG_CAP_LIMIT   = 1'b1;

  localparam int COUNT_W = 13;

  // Datapath commands, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE      = 4'd0,
    CMD_LOAD      = 4'd1,  // latch input item
    CMD_POP       = 4'd2,  // read top, drop depth
    CMD_PUSH      = 4'd3,  // push cur address if allowed, advance
    CMD_RD_I      = 4'd4,  // read entry i (base)
    CMD_SETBASE   = 4'd5,  // latch base from read data, j=1, k=i+1
    CMD_RD_K      = 4'd6,  // read entry k
    CMD_CMP_K     = 4'd7,  // compare entry k with want
    CMD_RD_TOP    = 4'd8,  // read top entry, drop depth
    CMD_SWAP      = 4'd9,  // write top into k
    CMD_FINISH    = 4'd10, // emit result
    CMD_NEXT_I    = 4'd11, // advance start
    CMD_TAKE_J    = 4'd12, // start removal of page j: k=i
    CMD_RES_INIT  = 4'd13, // reserve: k=0, want=addr
    CMD_POP_FIN   = 4'd14, // latch popped entry, emit result
    CMD_TAKE_INIT = 4'd15  // enter removal phase: j=0
  } cmd_t;

  typedef struct packed {
    logic act_alloc_one;
    logic act_free_one;
    logic act_alloc_run;
    logic act_free_run;
    logic act_reserve;
    logic pop_ok;       // depth > 0
    logic run_bad;      // n == 0 or n > depth
    logic run_skip;     // free_run with addr 0 or n 0
    logic push_done;    // all pushes issued
    logic i_over;       // i > depth - n
    logic k_end;        // k >= depth
    logic hit;          // entry k equals want
    logic search_done;  // j >= n or i+j >= depth
    logic found_all;    // found == n
    logic take_done;    // j >= n during removal
    logic is_reserve;
  } status_t;

endpackage

/* hw/rtl/fpsa_dp.sv */
// Datapath of the free-page stack allocator: frame memory, depth, indices.
// Depends on fpsa_pkg; driven by fpsa_ctrl commands.
module fpsa_dp
  import fpsa_pkg::*;
#(
  parameter int DEPTH     = 4096,
  parameter int PAGE_BITS = 12,
  parameter int ADDR_BITS = 52
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic [2:0]           in_action,
  input  logic [ADDR_BITS-1:0] in_page_address,
  input  logic [COUNT_W-1:0]   in_run_len,
  input  logic [ADDR_BITS-1:0] min_address,
  input  logic [COUNT_W-1:0]   capacity_limit,
  output status_t              status,
  output logic                 out_valid,
  output logic [ADDR_BITS-1:0] out_result_address,
  output logic [COUNT_W-1:0]   out_free_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int DW = IW + 1;
  localparam int EW = ADDR_BITS - PAGE_BITS;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_r;

  logic [DW-1:0] depth_r, depth_nxt;
  logic [2:0] act_r;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;   // push address / want
  logic [COUNT_W-1:0] n_r;
  logic [DW-1:0] i_r, i_nxt, k_r, k_nxt;
  logic [COUNT_W:0] j_r, j_nxt;
  logic [ADDR_BITS-1:0] base_r, base_nxt;
  logic [ADDR_BITS-1:0] res_r, res_nxt;
  logic valid_r, valid_nxt;

  logic [DW-1:0] limit;
  logic [DW+COUNT_W:0] cap_ext;
  logic [ADDR_BITS-1:0] want;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [DW-1:0] rd_idx;
  logic rd_en, wr_en;
  logic [DW-1:0] wr_idx;
  logic [EW-1:0] wr_data;
  logic push_ok;
  logic [DW+COUNT_W:0] n_ext, d_ext, i_ext, j_ext;

  assign cap_ext = (DW+COUNT_W+1)'(capacity_limit);
  assign limit   = (cap_ext < (DW+COUNT_W+1)'(DEPTH)) ? DW'(capacity_limit) : DW'(DEPTH);
  assign n_ext   = (DW+COUNT_W+1)'(n_r);
  assign d_ext   = (DW+COUNT_W+1)'(depth_r);
  assign i_ext   = (DW+COUNT_W+1)'(i_r);
  assign j_ext   = (DW+COUNT_W+1)'(j_r);
  assign want    = base_r + (ADDR_BITS'(j_r) << PAGE_BITS);
  assign rd_addr = {rdata_r, {PAGE_BITS{1'b0}}};

  assign push_ok = (addr_r != '0) && (addr_r[PAGE_BITS-1:0] == '0)
                   && (addr_r >= min_address) && (depth_r < limit);

  always_comb begin
    status               = '0;
    status.act_alloc_one = (act_r == ACT_ALLOC_ONE);
    status.act_free_one  = (act_r == ACT_FREE_ONE);
    status.act_alloc_run = (act_r == ACT_ALLOC_RUN);
    status.act_free_run  = (act_r == ACT_FREE_RUN);
    status.act_reserve   = (act_r == ACT_RESERVE);
    status.is_reserve    = status.act_reserve;
    status.pop_ok        = (depth_r != '0);
    status.run_bad       = (n_r == '0) || (n_ext > d_ext);
    status.run_skip      = (addr_r == '0) || (n_r == '0);
    status.push_done     = (j_ext >= n_ext);
    status.i_over        = (i_ext + n_ext > d_ext);
    status.k_end         = (k_r >= depth_r);
    status.hit           = (rd_addr == addr_r);
    status.search_done   = (j_ext >= n_ext) || (i_ext + j_ext >= d_ext);
    status.found_all     = (j_ext >= n_ext);
    status.take_done     = (j_ext >= n_ext);
  end

  always_comb begin
    depth_nxt = depth_r;
    addr_nxt  = addr_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    base_nxt  = base_r;
    res_nxt   = res_r;
    valid_nxt = 1'b0;
    rd_en     = 1'b0;
    rd_idx    = k_r;
    wr_en     = 1'b0;
    wr_idx    = depth_r;
    wr_data   = addr_r[ADDR_BITS-1:PAGE_BITS];
    case (cmd)
      CMD_LOAD: begin
        addr_nxt = in_page_address;
        res_nxt  = '0;
        i_nxt    = '0;
        j_nxt    = '0;
      end
      CMD_POP: begin
        depth_nxt = depth_r - DW'(1);
        rd_en     = 1'b1;
        rd_idx    = depth_r - DW'(1);
      end
      CMD_PUSH: begin
        if (push_ok) begin
          wr_en     = 1'b1;
          depth_nxt = depth_r + DW'(1);
        end
        addr_nxt = addr_r + (ADDR_BITS'(1) << PAGE_BITS);
        j_nxt    = j_r + (COUNT_W+1)'(1);
      end
      CMD_RD_I: begin
        rd_en  = 1'b1;
        rd_idx = i_r;
      end
      CMD_SETBASE: begin
        base_nxt = rd_addr;
        j_nxt    = (COUNT_W+1)'(1);
        k_nxt    = i_r + DW'(1);
        addr_nxt = rd_addr + (ADDR_BITS'(1) << PAGE_BITS);
      end
      CMD_RD_K: begin
        rd_en  = 1'b1;
        rd_idx = k_r;
      end
      CMD_CMP_K: begin
        // on a hit in the search phase, move to the next page j
        if (rd_addr == addr_r) begin
          j_nxt    = j_r + (COUNT_W+1)'(1);
          k_nxt    = i_r + DW'(j_r) + DW'(1);
          addr_nxt = base_r + (ADDR_BITS'(j_r + (COUNT_W+1)'(1)) << PAGE_BITS);
        end else begin
          k_nxt = k_r + DW'(1);
        end
      end
      CMD_RD_TOP: begin
        rd_en  = 1'b1;
        rd_idx = depth_r - DW'(1);
        depth_nxt = depth_r - DW'(1);
      end
      CMD_SWAP: begin
        wr_en   = 1'b1;
        wr_idx  = k_r;
        wr_data = rdata_r;
        j_nxt   = j_r + (COUNT_W+1)'(1);
      end
      CMD_TAKE_INIT: begin
        j_nxt = '0;
      end
      CMD_TAKE_J: begin
        k_nxt    = i_r;
        addr_nxt = want;
        if (j_r == '0) res_nxt = base_r;
      end
      CMD_NEXT_I: begin
        i_nxt = i_r + DW'(1);
      end
      CMD_RES_INIT: begin
        k_nxt = '0;
      end
      CMD_POP_FIN: begin
        valid_nxt = 1'b1;
        res_nxt   = rd_addr;
      end
      CMD_FINISH: begin
        valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_idx[IW-1:0]];
    if (wr_en) mem[wr_idx[IW-1:0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      valid_r <= 1'b0;
      act_r   <= '0;
    end else begin
      depth_r <= depth_nxt;
      valid_r <= valid_nxt;
      if (cmd == CMD_LOAD) act_r <= in_action;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    j_r    <= (cmd == CMD_SWAP && status.is_reserve) ? j_r : j_nxt;
    base_r <= base_nxt;
    res_r  <= res_nxt;
    if (cmd == CMD_LOAD) n_r <= in_run_len;
  end

  assign out_valid          = valid_r;
  assign out_result_address = res_r;
  assign out_free_count     = COUNT_W'(depth_r);

endmodule

/* hw/rtl/fpsa_ctrl.sv */
// Controller state machine of the free-page stack allocator.
// Depends on fpsa_pkg; sequences fpsa_dp through cmd_t commands.
module fpsa_ctrl
  import fpsa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DECODE = 12'b000000000010,
    S_POPW   = 12'b000000000100,
    S_PUSH   = 12'b000000001000,
    S_RDI    = 12'b000000010000,
    S_BASE   = 12'b000000100000,
    S_RDK    = 12'b000001000000,
    S_CMPK   = 12'b000010000000,
    S_TAKE   = 12'b000100000000,
    S_TOP    = 12'b001000000000,
    S_SWAP   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   take_r, take_nxt;   // removal phase of alloc_run

  always_comb begin
    state_nxt = state_r;
    take_nxt  = take_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DECODE;
          take_nxt  = 1'b0;
        end
      end
      S_DECODE: begin
        if (status.act_alloc_one && status.pop_ok) begin
          cmd = CMD_POP; state_nxt = S_POPW;
        end else if (status.act_free_one) begin
          cmd = CMD_PUSH; state_nxt = S_DONE;
        end else if (status.act_free_run && !status.run_skip) begin
          state_nxt = S_PUSH;
        end else if (status.act_alloc_run && !status.run_bad) begin
          state_nxt = S_RDI;
        end else if (status.act_reserve) begin
          cmd = CMD_RES_INIT; state_nxt = S_RDK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POPW: begin
        cmd = CMD_POP_FIN; state_nxt = S_IDLE;
      end
      S_PUSH: begin
        if (status.push_done) state_nxt = S_DONE;
        else cmd = CMD_PUSH;
      end
      S_RDI: begin
        if (status.i_over) state_nxt = S_DONE;
        else begin
          cmd = CMD_RD_I; state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        cmd = CMD_SETBASE; state_nxt = S_RDK;
      end
      S_RDK: begin
        if (status.k_end) begin
          if (status.is_reserve || take_r) state_nxt = S_DONE;
          else if (status.found_all) begin
            cmd = CMD_TAKE_INIT; state_nxt = S_TAKE; take_nxt = 1'b1;
          end else begin
            cmd = CMD_NEXT_I; state_nxt = S_RDI;
          end
        end else if (!status.is_reserve && !take_r && status.search_done) begin
          if (status.found_all) begin
            cmd = CMD_TAKE_INIT; state_nxt = S_TAKE; take_nxt = 1'b1;
          end else begin
            cmd = CMD_NEXT_I; state_nxt = S_RDI;
          end
        end else begin
          cmd = CMD_RD_K; state_nxt = S_CMPK;
        end
      end
      S_CMPK: begin
        if (status.hit && (take_r || status.is_reserve)) state_nxt = S_TOP;
        else begin
          // search hits advance j; removal/reserve misses advance k
          cmd = CMD_CMP_K;
          state_nxt = S_RDK;
        end
      end
      S_TOP: begin
        cmd = CMD_RD_TOP; state_nxt = S_SWAP;
      end
      S_SWAP: begin
        cmd = CMD_SWAP;
        state_nxt = status.is_reserve ? S_DONE : S_TAKE;
      end
      S_TAKE: begin
        if (status.take_done) state_nxt = S_DONE;
        else begin
          cmd = CMD_TAKE_J; state_nxt = S_RDK;
        end
      end
      S_DONE: begin
        cmd = CMD_FINISH; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      take_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      take_r  <= take_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* hw/rtl/free_page_stack_allocator_top.sv */
// Free-page stack allocator: keeps a stack of free page addresses in an
// on-chip memory of DEPTH entries. Operations: alloc_one, free_one,
// alloc_run, free_run, reserve.
// Input: an item is taken on a clock edge with start high and busy low.
// Output: out_valid pulses for one cycle with result_address and free_count;
// the receiver cannot stall, so results are never held.
// Sequencing: alloc_one and free_one go from the accepting edge through load,
// decode with the memory access (a registered read of the frame memory) and
// result to out_valid; busy drops in the result cycle, so a new item can be
// taken once the result is out. free_run pushes the pages of the run one after
// another. Reserve walks the stack, reading and comparing each entry, and swaps
// the top into a hit; alloc_run tries each start, compares entries and removes
// each page of a found run, roughly quadratic in depth in the worst case.
// Reset (rst_n low, synchronous) empties the stack at once and loads
// min_address = 0x100000 and capacity_limit = 4096; no clearing pass.
// Configuration writes are always accepted (cfg_ready high) and must only
// be issued while busy is low.
module free_page_stack_allocator_top
  import fpsa_pkg::*;
#(
  parameter int DEPTH     = 4096,
  parameter int PAGE_BITS = 12,
  parameter int ADDR_BITS = 52
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_action,
  input  logic [ADDR_BITS-1:0] in_page_address,
  input  logic [COUNT_W-1:0]   in_run_len,
  output logic                 out_valid,
  output logic [ADDR_BITS-1:0] out_result_address,
  output logic [COUNT_W-1:0]   out_free_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam logic [ADDR_BITS-1:0] MIN_ADDR_RESET = ADDR_BITS'(64'h100000);

  logic [ADDR_BITS-1:0] min_address_r;
  logic [COUNT_W-1:0]   capacity_limit_r;
  cmd_t                 cmd;
  status_t              status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_address_r    <= MIN_ADDR_RESET;
      capacity_limit_r <= COUNT_W'(4096);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MIN_ADDRESS) min_address_r <= cfg_data[ADDR_BITS-1:0];
      else capacity_limit_r <= cfg_data[COUNT_W-1:0];
    end
  end

  fpsa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  fpsa_dp #(
    .DEPTH     (DEPTH),
    .PAGE_BITS (PAGE_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_action          (in_action),
    .in_page_address    (in_page_address),
    .in_run_len         (in_run_len),
    .min_address        (min_address_r),
    .capacity_limit     (capacity_limit_r),
    .status             (status),
    .out_valid          (out_valid),
    .out_result_address (out_result_address),
    .out_free_count     (out_free_count)
  );

  a_no_start_twice: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item not taken");
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(!busy))
    else $error("result without item");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_free_count) <= DEPTH))
    else $error("free count beyond depth");

endmodule

/* sim/fpsa_checker.sv */
`timescale 1ns / 100ps
// Checker for the free-page stack allocator: watches the command, result and
// configuration channels, predicts each result and compares it. Uses fpsa_pkg.
module fpsa_checker
  import fpsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_action,
  input  logic [51:0]        in_page_address,
  input  logic [COUNT_W-1:0] in_run_len,
  input  logic               out_valid,
  input  logic [51:0]        out_result_address,
  input  logic [COUNT_W-1:0] out_free_count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int STACK_DEPTH = 4096;

  typedef struct packed {
    logic [51:0]        addr;
    logic [COUNT_W-1:0] count;
  } page_result_t;

  logic [51:0]  frames [STACK_DEPTH];
  int           depth;
  logic [51:0]  min_addr;
  int           cap_limit;
  page_result_t result_q[$];

  function automatic logic [51:0] page_at(logic [51:0] base, int j);
    logic [51:0] offs;
    offs = 52'(j) << 12;
    return base + offs;
  endfunction

  function automatic void push_frame(logic [51:0] a);
    int lim;
    lim = (cap_limit < STACK_DEPTH) ? cap_limit : STACK_DEPTH;
    if (a == 0 || a[11:0] != 0 || a < min_addr || depth >= lim) return;
    frames[depth] = a;
    depth++;
  endfunction

  function automatic void take_frame(int from, logic [51:0] target);
    for (int k = from; k < depth; k++) begin
      if (frames[k] == target) begin
        depth--;
        frames[k] = frames[depth];
        return;
      end
    end
  endfunction

  function automatic logic [51:0] alloc_contig(int n);
    logic [51:0] base;
    int          found;
    bit          hit;
    if (n == 0 || n > depth) return 0;
    for (int i = 0; i <= depth - n; i++) begin
      base = frames[i];
      found = 1;
      for (int j = 1; j < n && i + j < depth; j++) begin
        hit = 0;
        for (int k = i + j; k < depth; k++) begin
          if (frames[k] == page_at(base, j)) begin
            hit = 1;
            break;
          end
        end
        if (!hit) break;
        found++;
      end
      if (found == n) begin
        for (int j = 0; j < n; j++) take_frame(i, page_at(base, j));
        return base;
      end
    end
    return 0;
  endfunction

  function automatic page_result_t predict_page_op(logic [2:0] act, logic [51:0] a,
                                                   int n);
    page_result_t r;
    r.addr = 0;
    case (act)
      ACT_ALLOC_ONE: begin
        if (depth > 0) begin
          depth--;
          r.addr = frames[depth];
        end
      end
      ACT_FREE_ONE: push_frame(a);
      ACT_ALLOC_RUN: r.addr = alloc_contig(n);
      ACT_FREE_RUN: begin
        if (a != 0 && n != 0)
          for (int i = 0; i < n; i++) push_frame(page_at(a, i));
      end
      ACT_RESERVE: take_frame(0, a);
      default: ;
    endcase
    r.count = COUNT_W'(depth);
    return r;
  endfunction

  always @(posedge clk) begin
    page_result_t exp_r;
    if (!rst_n) begin
      depth = 0;
      min_addr = 52'h100000;
      cap_limit = 4096;
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MIN_ADDRESS) min_addr = cfg_data[51:0];
        else cap_limit = int'(cfg_data[COUNT_W-1:0]);
      end
      if (start && !busy)
        result_q.push_back(predict_page_op(in_action, in_page_address, int'(in_run_len)));
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $error("result with no transfer outstanding: addr %h count %0d",
                 out_result_address, out_free_count);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r.addr !== out_result_address || exp_r.count !== out_free_count)
            fail_count <= fail_count + 1;
          if (exp_r.addr !== out_result_address)
            $error("result_address: expected %h, actual %h", exp_r.addr, out_result_address);
          if (exp_r.count !== out_free_count)
            $error("free_count: expected %0d, actual %0d", exp_r.count, out_free_count);
        end
      end
    end
    pending <= result_q.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Top of the free-page stack allocator testbench: drives commands and register
// writes in phases, gives the verdict. Needs fpsa_pkg, the top and fpsa_checker.
module tb_top;
  import fpsa_pkg::*;

  localparam longint CYCLE_LIMIT = 40000000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic [2:0]         in_action = ACT_ALLOC_ONE;
  logic [51:0]        in_page_address = '0;
  logic [COUNT_W-1:0] in_run_len = '0;
  logic               out_valid;
  logic [51:0]        out_result_address;
  logic [COUNT_W-1:0] out_free_count;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic               cfg_index = CFG_MIN_ADDRESS;
  logic [63:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  longint             cycles = 0;
  int                 burst_left = 0;
  int                 last_free = 0;
  int                 cur_cap = 4096;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  free_page_stack_allocator_top uut (.*);
  fpsa_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_valid) last_free <= int'(out_free_count);
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One command transfer; start stays high into a burst, drops for a gap.
  task automatic issue_op(logic [2:0] act, logic [51:0] a, int n);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1;
    in_action <= act;
    in_page_address <= a;
    in_run_len <= COUNT_W'(n);
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [63:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic logic [51:0] pick_address();
    int sel;
    logic [51:0] pool;
    sel = $urandom_range(0, 99);
    pool = 52'h200000 + (52'($urandom_range(0, 47)) << 12);
    if (sel < 70) return pool;
    if (sel < 78) return pool | 52'($urandom_range(1, 4095));
    if (sel < 83) return 0;
    if (sel < 90) return 52'({$urandom, $urandom} & 64'hFFFFFFFFFFFFF);
    if (sel < 95) return 52'hFFFFFFFFFF000 - (52'($urandom_range(0, 3)) << 12);
    return 52'($urandom_range(1, 255)) << 12;
  endfunction

  task automatic random_ops(int count);
    int sel;
    logic [2:0] act;
    int n;
    for (int it = 0; it < count; it++) begin
      sel = $urandom_range(0, 99);
      // hold depth down so run searches stay short
      if (last_free > 40 && sel < 60) act = ACT_ALLOC_ONE;
      else if (sel < 25) act = ACT_ALLOC_ONE;
      else if (sel < 50) act = ACT_FREE_ONE;
      else if (sel < 70) act = ACT_ALLOC_RUN;
      else if (sel < 90) act = ACT_FREE_RUN;
      else if (sel < 98) act = ACT_RESERVE;
      else act = 3'($urandom_range(5, 7));
      n = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 10);
      // keep long frees out of a roomy stack
      if (act == ACT_FREE_RUN && cur_cap > 64 && n > 10) n = $urandom_range(0, 10);
      issue_op(act, pick_address(), n);
    end
  endtask

  task automatic set_regs(logic [51:0] lo, int cap, logic [63:0] noise);
    cur_cap = cap;
    write_reg(CFG_MIN_ADDRESS, {noise[63:52], lo});
    write_reg(CFG_CAP_LIMIT, {noise[63:13], 13'(cap)});
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    issue_op(ACT_ALLOC_ONE, 0, 0);
    issue_op(ACT_FREE_ONE, 0, 0);
    issue_op(ACT_FREE_ONE, 52'h200800, 0);
    issue_op(ACT_FREE_ONE, 52'h0FF000, 0);
    issue_op(ACT_FREE_ONE, 52'h200000, 0);
    issue_op(ACT_FREE_RUN, 52'h201000, 3);
    issue_op(ACT_ALLOC_RUN, 0, 0);
    issue_op(ACT_ALLOC_RUN, 0, 5);
    issue_op(ACT_ALLOC_RUN, 0, 2);
    issue_op(ACT_FREE_RUN, 0, 2);
    issue_op(ACT_FREE_RUN, 52'h300000, 0);
    issue_op(ACT_RESERVE, 52'h203000, 0);
    issue_op(ACT_RESERVE, 52'h999000, 0);
    issue_op(3'd5, 52'h200000, 1);
    issue_op(3'd7, 52'hFFFFFFFFFFFFF, 13'h1FFF);
    // wrap past the top of the address space
    issue_op(ACT_FREE_RUN, 52'hFFFFFFFFFE000, 4);
    issue_op(ACT_ALLOC_RUN, 0, 2);
    issue_op(ACT_FREE_ONE, 52'hFFFFFFFFFF000, 0);
    issue_op(ACT_FREE_RUN, 52'hFFFFFFFFFF000, 2);
    issue_op(ACT_ALLOC_RUN, 0, 3);
    issue_op(ACT_ALLOC_ONE, 0, 0);
    drain_results();

    set_regs(52'h1000, 0, 64'hFFFFFFFFFFFFFFFF);
    issue_op(ACT_FREE_RUN, 52'h200000, 4096);
    issue_op(ACT_FREE_ONE, 52'h200000, 0);
    random_ops(60);
    drain_results();

    set_regs(0, 32, {$urandom, $urandom});
    random_ops(400);
    drain_results();
    set_regs(52'h210000, 16, {$urandom, $urandom});
    random_ops(250);
    drain_results();
    set_regs(52'hFFFFFFFFFFFFF, 8, {$urandom, $urandom});
    random_ops(100);
    drain_results();
    set_regs(52'h100000, 4096, 0);
    random_ops(400);
    drain_results();
    // cap drops below the current depth
    set_regs(52'h0, 1, {$urandom, $urandom});
    random_ops(200);
    drain_results();
    set_regs(52'({$urandom, $urandom} & 64'h3FF000), 24, {$urandom, $urandom});
    random_ops(200);
    drain_results();
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
